// File: rtl/hlxfr_pkg.sv
// Shared types and constants for the length-prefixed XOR frame receiver.
// No dependencies; every other file in rtl imports this package.
package hlxfr_pkg;

    localparam logic [7:0] CHR_U     = 8'h55;
    localparam logic [7:0] CHR_N     = 8'h4E;
    localparam logic [7:0] CHR_E     = 8'h45;
    localparam logic [7:0] CHR_R     = 8'h52;
    localparam logic [7:0] CHR_COLON = 8'h3A;

    // XOR of the four header bytes and the token, folded in at frame start.
    localparam logic [7:0] CHECK_SEED = CHR_U ^ CHR_N ^ CHR_E ^ CHR_R ^ CHR_COLON;

    localparam logic [7:0] TIMEOUT_RESET = 8'd5;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_GOOD  = 2'd2,
        KIND_BAD   = 2'd3
    } t_kind;

    typedef enum logic [6:0] {
        ST_HUNT    = 7'b0000001,
        ST_H1      = 7'b0000010,
        ST_H2      = 7'b0000100,
        ST_H3      = 7'b0001000,
        ST_LEN     = 7'b0010000,
        ST_TOKEN   = 7'b0100000,
        ST_PAYLOAD = 7'b1000000
    } t_state;

    typedef struct packed {
        logic        has;
        t_kind       kind;
        logic [7:0]  value;
        logic [7:0]  position;
    } t_result;

endpackage

// File: rtl/hlxfr_parse.sv
// Frame parser: header hunt, length and token checks, payload and XOR check.
// Depends on hlxfr_pkg. Holds all parser state; the result it gives is combinational.
module hlxfr_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_cmd,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_reload,
    output hlxfr_pkg::t_result o_res
);
    import hlxfr_pkg::*;

    t_state     r_state, n_state;
    logic [7:0] r_left, n_left;
    logic [7:0] r_check, n_check;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_tmo, n_tmo;
    logic       is_u;

    assign is_u = (i_byte == CHR_U);

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        n_check = r_check;
        n_pos   = r_pos;
        n_tmo   = r_tmo;
        o_res   = '{has: 1'b0, kind: KIND_START, value: 8'd0, position: 8'd0};

        if (i_cmd) begin
            if (r_tmo != 8'd0) begin
                n_tmo = r_tmo - 8'd1;
            end else begin
                n_state = ST_HUNT;
            end
        end else begin
            n_tmo = i_reload;
            unique case (r_state)
                ST_H1, ST_H2, ST_H3, ST_HUNT: begin
                    if (r_state == ST_H1 && i_byte == CHR_N) begin
                        n_state = ST_H2;
                    end else if (r_state == ST_H2 && i_byte == CHR_E) begin
                        n_state = ST_H3;
                    end else if (r_state == ST_H3 && i_byte == CHR_R) begin
                        n_state = ST_LEN;
                    end else begin
                        // A mismatch is looked at again as a possible first header byte.
                        n_state = is_u ? ST_H1 : ST_HUNT;
                        if (is_u) begin
                            n_check = 8'd0;
                        end
                    end
                end
                ST_LEN: begin
                    n_left  = i_byte;
                    n_state = ST_TOKEN;
                end
                ST_TOKEN: begin
                    if (i_byte != CHR_COLON) begin
                        n_state = is_u ? ST_H1 : ST_HUNT;
                        if (is_u) begin
                            n_check = 8'd0;
                        end
                    end else if (r_left == 8'd0) begin
                        n_state = ST_HUNT;
                        o_res   = '{has: 1'b1, kind: KIND_BAD, value: 8'd0, position: 8'd0};
                    end else begin
                        n_check = CHECK_SEED ^ r_left;
                        n_pos   = 8'd1;
                        n_state = ST_PAYLOAD;
                        o_res   = '{has: 1'b1, kind: KIND_START, value: r_left,
                                    position: 8'd0};
                    end
                end
                ST_PAYLOAD: begin
                    if (r_left > 8'd1) begin
                        n_check = r_check ^ i_byte;
                        n_pos   = r_pos + 8'd1;
                        n_left  = r_left - 8'd1;
                        o_res   = '{has: 1'b1, kind: KIND_DATA, value: i_byte,
                                    position: r_pos};
                    end else begin
                        n_left  = 8'd0;
                        n_state = ST_HUNT;
                        o_res   = '{has: 1'b1,
                                    kind: (r_check == i_byte) ? KIND_GOOD : KIND_BAD,
                                    value: i_byte, position: 8'd0};
                    end
                end
                default: begin
                    n_state = ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_left  <= 8'd0;
            r_check <= 8'd0;
            r_pos   <= 8'd0;
            r_tmo   <= 8'd0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_left  <= n_left;
            r_check <= n_check;
            r_pos   <= n_pos;
            r_tmo   <= n_tmo;
        end
    end

endmodule

// File: rtl/hlxfr_outreg.sv
// Result register with valid/stall handshake toward the consumer.
// Depends on hlxfr_pkg for the result struct.
module hlxfr_outreg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  hlxfr_pkg::t_result i_res,
    input  logic               i_stall,
    output logic               o_free,
    output logic               o_valid,
    output hlxfr_pkg::t_result o_res
);
    import hlxfr_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    // The register can take a new result when empty or when its content leaves now.
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: rtl/header_length_xor_frame_receiver.sv
// Top level of the length-prefixed frame receiver with XOR check.
// Depends on hlxfr_pkg, hlxfr_parse and hlxfr_outreg.
//
// Usage: the input channel (i_in_valid, o_in_stall, i_cmd, i_rx_byte) carries
// either a received byte (i_cmd low) or a timer tick (i_cmd high). A transfer
// happens at a rising edge where valid is high and stall is low. The parser
// hunts for the header "UNER", takes a length byte and a ':' token, and then
// reports frame start, each payload byte with its position, and finally frame
// good or frame bad on the output channel (o_out_valid, i_out_stall, o_kind,
// o_value, o_position). Ticks count down a timeout that every byte reloads
// from the configuration register; a tick at zero drops back to the hunt.
// Timing: an input transfer is held in the input register, and its result is
// loaded into the result register when the item advances, so o_out_valid
// rises once the result is registered, and the result leaves at the edge where
// i_out_stall is low. Throughput is one item per cycle while no stall holds the
// flow, set by the single pass of parser logic between the two registers.
// When the receiver stalls, a waiting result holds; items that produce no result
// still flow, and the input stalls only once an item with a result finds the result
// register full. Reset (synchronous, active low) empties both registers, returns
// the parser to the hunt and sets the timeout reload to 5. i_cfg_wr_en/i_cfg_wr_data
// write the reload, which the user must do only while idle; the block does not check.
module header_length_xor_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_value,
    output logic [7:0] o_position
);
    import hlxfr_pkg::*;

    logic [7:0] r_timeout_reload;
    logic       r_in_valid, n_in_valid;
    logic       r_cmd;
    logic [7:0] r_byte;
    logic       in_accept;
    logic       advance;
    logic       out_free;
    t_result    parse_res;
    t_result    out_res;

    // An item in the input register moves on when it makes no result, or when
    // the result register can take what it makes.
    assign advance    = r_in_valid && (!parse_res.has || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_timeout_reload <= TIMEOUT_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_wr_en) begin
                r_timeout_reload <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd  <= i_cmd;
            r_byte <= i_rx_byte;
        end
    end

    hlxfr_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_cmd    (r_cmd),
        .i_byte   (r_byte),
        .i_reload (r_timeout_reload),
        .o_res    (parse_res)
    );

    hlxfr_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && parse_res.has),
        .i_res   (parse_res),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_kind     = out_res.kind;
    assign o_value    = out_res.value;
    assign o_position = out_res.position;

endmodule
